>>> rtl/core/ascii_decimal_frame_receiver_macros.svh
// Assertion macros used by the receiver's top level.
`ifndef ASCII_DECIMAL_FRAME_RECEIVER_MACROS_SVH
`define ASCII_DECIMAL_FRAME_RECEIVER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ADFR_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// An implication checked at every clock edge out of reset.
`define ADFR_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/adfr_pkg.sv
// Types and constants of the ASCII decimal frame receiver.
package adfr_pkg;

	localparam int STORE_DEPTH = 8;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [7:0] MIN_ID_RESET = 8'd10;

	typedef enum logic [2:0] {
		EV_DIGIT,
		EV_SPACE,
		EV_PLUS,
		EV_MINUS,
		EV_OTHER,
		EV_END_FIELD,
		EV_END_FRAME
	} ev_kind_t;

	typedef struct packed {
		ev_kind_t   kind;
		logic [3:0] digit;
	} event_t;

	typedef enum logic [1:0] {
		PH_ID,
		PH_LENGTH,
		PH_DATA,
		PH_CHECKSUM
	} phase_t;

	typedef enum logic [1:0] {
		SC_LEADING,
		SC_SIGN,
		SC_DIGITS,
		SC_ENDED
	} scan_t;

	typedef enum logic [1:0] {
		ST_VALID,
		ST_CHECKSUM,
		ST_ID_LOW,
		ST_LENGTH
	} status_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef struct packed {
		logic pop_frame;
	} back_status_t;

endpackage

>>> rtl/core/adfr_front.sv
// Input stage: accepts received bytes and classifies each into a parser event.
module adfr_front
	import adfr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       ev_valid,
	output event_t     ev,
	input  logic       ev_ready
);

	logic   valid_s1;
	event_t ev_s1;
	event_t ev_class;
	logic   take;

	assign in_stall = valid_s1 && !ev_ready;
	assign take     = in_valid && !in_stall;
	assign ev_valid = valid_s1;
	assign ev       = ev_s1;

	always_comb begin
		ev_class.digit = rx_byte[3:0];
		unique case (rx_byte) inside
			CH_NUL: ev_class.kind = EV_END_FIELD;
			CH_NL: ev_class.kind = EV_END_FRAME;
			CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: ev_class.kind = EV_SPACE;
			CH_PLUS: ev_class.kind = EV_PLUS;
			CH_MINUS: ev_class.kind = EV_MINUS;
			[CH_ZERO:CH_NINE]: ev_class.kind = EV_DIGIT;
			default: ev_class.kind = EV_OTHER;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (ev_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ev_s1 <= ev_class;
		end
	end

endmodule

>>> rtl/core/adfr_queue.sv
// Short event queue between the classifying front and the parsing back.
module adfr_queue
	import adfr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  event_t        push_data,
	input  logic          pop,
	output event_t        pop_data,
	output queue_status_t status
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	event_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/core/adfr_back.sv
// Parser back end: field bookkeeping, data store, frame check and result register.
module adfr_back
	import adfr_pkg::*;
#(
	parameter int MAX_DATA_BYTES = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         ev_valid,
	input  event_t       ev,
	output logic         ev_pop,
	input  logic [7:0]   min_valid_id,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [1:0]   frame_status,
	output logic [7:0]   frame_id,
	output logic [7:0]   frame_length,
	output logic [7:0]   data_byte [STORE_DEPTH],
	output back_status_t status
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_DATA_BYTES);

	phase_t      phase_q;
	scan_t       scan_q;
	logic        neg_q;
	logic [15:0] acc_q;
	logic [7:0]  id_q;
	logic [7:0]  len_q;
	logic [3:0]  count_q;
	logic [7:0]  store_q [STORE_DEPTH];
	logic [15:0] cks_q;

	logic        out_valid_q;
	status_t     out_status_q;
	logic [7:0]  out_id_q;
	logic [7:0]  out_len_q;
	logic [7:0]  out_data_q [STORE_DEPTH];

	logic        out_free;
	logic        pop_frame;
	logic [15:0] acc_next;
	logic [15:0] field_val;
	logic [7:0]  limit;
	logic        store_slot;
	logic [11:0] sum;
	status_t     check;

	assign out_free  = !out_valid_q || !out_stall;
	assign ev_pop    = ev_valid && ((ev.kind != EV_END_FRAME) || out_free);
	assign pop_frame = ev_pop && (ev.kind == EV_END_FRAME);
	assign status.pop_frame = pop_frame;

	assign acc_next   = {acc_q[12:0], 3'b000} + {acc_q[14:0], 1'b0} + {12'b0, ev.digit};
	assign field_val  = neg_q ? (~acc_q + 16'd1) : acc_q;
	assign limit      = (len_q < MAX_LEN) ? len_q : MAX_LEN;
	assign store_slot = ({4'b0, count_q} < limit) && (count_q < 4'(STORE_DEPTH));

	always_comb begin
		sum = {4'b0, id_q} + {4'b0, len_q};
		for (int i = 0; i < STORE_DEPTH; i++) begin
			if (8'(i) < len_q) begin
				sum = sum + {4'b0, store_q[i]};
			end
		end
		if (len_q > MAX_LEN) begin
			check = ST_LENGTH;
		end else if ({4'b0, sum} != cks_q) begin
			check = ST_CHECKSUM;
		end else if (id_q < min_valid_id) begin
			check = ST_ID_LOW;
		end else begin
			check = ST_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID;
			scan_q  <= SC_LEADING;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			id_q    <= '0;
			len_q   <= '0;
			count_q <= '0;
			cks_q   <= '0;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				store_q[i] <= '0;
			end
		end else if (ev_pop) begin
			unique case (ev.kind)
				EV_END_FRAME: begin
					phase_q <= PH_ID;
					count_q <= '0;
					scan_q  <= SC_LEADING;
					neg_q   <= 1'b0;
					acc_q   <= '0;
				end
				EV_END_FIELD: begin
					scan_q <= SC_LEADING;
					neg_q  <= 1'b0;
					acc_q  <= '0;
					unique case (phase_q)
						PH_ID: begin
							id_q    <= field_val[7:0];
							phase_q <= PH_LENGTH;
						end
						PH_LENGTH: begin
							len_q   <= field_val[7:0];
							phase_q <= PH_DATA;
						end
						PH_DATA: begin
							if (store_slot) begin
								store_q[count_q[IDX_W-1:0]] <= field_val[7:0];
								count_q <= count_q + 4'd1;
							end else begin
								cks_q   <= field_val;
								phase_q <= PH_CHECKSUM;
							end
						end
						PH_CHECKSUM: begin
							cks_q <= field_val;
						end
						default: begin
							phase_q <= PH_ID;
						end
					endcase
				end
				default: begin
					if (scan_q != SC_ENDED) begin
						unique case (ev.kind)
							EV_DIGIT: begin
								acc_q  <= acc_next;
								scan_q <= SC_DIGITS;
							end
							EV_SPACE: begin
								if (scan_q != SC_LEADING) begin
									scan_q <= SC_ENDED;
								end
							end
							EV_PLUS, EV_MINUS: begin
								if (scan_q == SC_LEADING) begin
									neg_q  <= (ev.kind == EV_MINUS);
									scan_q <= SC_SIGN;
								end else begin
									scan_q <= SC_ENDED;
								end
							end
							default: begin
								scan_q <= SC_ENDED;
							end
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_frame) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_frame) begin
			out_status_q <= check;
			out_id_q     <= id_q;
			out_len_q    <= len_q;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				out_data_q[i] <= (i < MAX_DATA_BYTES) ? store_q[i] : 8'd0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_status = out_status_q;
	assign frame_id     = out_id_q;
	assign frame_length = out_len_q;
	assign data_byte    = out_data_q;

endmodule

>>> rtl/core/ascii_decimal_frame_receiver.sv
// Top level of the ASCII decimal frame receiver.
// Throughput: one byte transaction per cycle while in_stall is low; the parser updates once per event.
// Result path: a newline transaction passes the classify register, a queue slot, then the parser's
// result register; it waits longer while the queue backs up or a held result stalls the frame end.
// Reset: all parser state and the data store clear at once, min_valid_id returns to 10.
`include "ascii_decimal_frame_receiver_macros.svh"

module ascii_decimal_frame_receiver
	import adfr_pkg::*;
#(
	parameter int MAX_DATA_BYTES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] frame_status,
	output logic [7:0] frame_id,
	output logic [7:0] frame_length,
	output logic [7:0] data_byte_0,
	output logic [7:0] data_byte_1,
	output logic [7:0] data_byte_2,
	output logic [7:0] data_byte_3,
	output logic [7:0] data_byte_4,
	output logic [7:0] data_byte_5,
	output logic [7:0] data_byte_6,
	output logic [7:0] data_byte_7
);

	logic [7:0]    min_valid_id_q;
	logic          front_valid;
	event_t        front_ev;
	event_t        queue_ev;
	queue_status_t q_st;
	logic          back_pop;
	back_status_t  back_st;
	logic [7:0]    data_byte [STORE_DEPTH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_valid_id_q <= MIN_ID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_valid_id_q <= cfg_data;
		end
	end

	adfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.ev_valid (front_valid),
		.ev       (front_ev),
		.ev_ready (!q_st.full)
	);

	adfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_data (front_ev),
		.pop       (back_pop),
		.pop_data  (queue_ev),
		.status    (q_st)
	);

	adfr_back #(
		.MAX_DATA_BYTES (MAX_DATA_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev_valid     (!q_st.empty),
		.ev           (queue_ev),
		.ev_pop       (back_pop),
		.min_valid_id (min_valid_id_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_status (frame_status),
		.frame_id     (frame_id),
		.frame_length (frame_length),
		.data_byte    (data_byte),
		.status       (back_st)
	);

	assign data_byte_0 = data_byte[0];
	assign data_byte_1 = data_byte[1];
	assign data_byte_2 = data_byte[2];
	assign data_byte_3 = data_byte[3];
	assign data_byte_4 = data_byte[4];
	assign data_byte_5 = data_byte[5];
	assign data_byte_6 = data_byte[6];
	assign data_byte_7 = data_byte[7];

	`ADFR_ASSERT_ALWAYS(a_queue_flags, !(q_st.full && q_st.empty), "queue full and empty at once")
	`ADFR_ASSERT_IMPLY(a_stall_cause, in_stall, q_st.full, "input stalled with room in the queue")
	`ADFR_ASSERT_IMPLY(a_result_source, $rose(out_valid), $past(back_st.pop_frame), "result without a frame end")

endmodule
